// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, cond, cons) \
  `ASSERT_CLK(label, (cond) |-> (cons))

`endif

// ===== hdl/mpk_pkg.sv =====
// ----------------------------------------------------------------------------
// mpk_pkg
// Types, constants and helpers of the multi-pattern match counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpk_pkg;

  localparam int MAX_PATTERNS    = 16;
  localparam int MAX_PATTERN_LEN = 16;
  localparam int COUNT_WIDTH     = 16;

  localparam int Cells   = MAX_PATTERNS * MAX_PATTERN_LEN;
  localparam int CellAw  = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int SlotW   = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int PosW    = $clog2(MAX_PATTERN_LEN + 1);
  localparam int HitW    = $clog2(MAX_PATTERNS + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [3:0] slot;
    logic [7:0] symbol;
  } mpk_in_t;

  typedef struct packed {
    logic [15:0] total_matches;
    logic [4:0]  matched_now;
    logic        text_done;
    logic        slot_full;
  } mpk_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SLOT,
    S_TAILW,
    S_STEP,
    S_CMP,
    S_FIN,
    S_TOTAL,
    S_OUT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch_in;
    logic clr_all;
    logic clr_pos;
    logic hits_clr;
    logic slot_init;
    logic slot_next;
    logic q_clr;
    logic q_from_pos;
    logic q_from_fail;
    logic q_inc;
    logic rd_tail;
    logic wr_text;
    logic wr_append;
    logic set_full;
    logic add_total;
    logic load_out;
  } mpk_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    cmd_e cmd;
    logic slot_ok;
    logic len_zero;
    logic len_full;
    logic pos_eq_len;
    logic q_zero;
    logic sym_eq;
    logic last_slot;
  } mpk_stat_t;

  // Flat cell address of a slot and position
  function automatic logic [CellAw-1:0] cell_addr(logic [SlotW-1:0] s, logic [PosW-1:0] p);
    cell_addr = CellAw'(32'(s) * MAX_PATTERN_LEN + 32'(p));
  endfunction

endpackage

// ===== hdl/mpk_ram.sv =====
// ----------------------------------------------------------------------------
// mpk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpk_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mpk_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpk_ctrl
// Sequencer: walks slots and failure links, drives the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpk_ctrl import mpk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  mpk_stat_t stat_i,
  output mpk_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.hits_clr = 1'b1;
        case (stat_i.cmd)
          CMD_CLEAR: begin
            cmd_o.clr_all = 1'b1;
            state_d       = S_OUT;
          end
          CMD_END: begin
            cmd_o.clr_pos = 1'b1;
            state_d       = S_OUT;
          end
          CMD_TEXT: begin
            cmd_o.slot_init = 1'b1;
            state_d         = S_SLOT;
          end
          default: begin
            // append: drop bad slot, flag full slot, else build border
            cmd_o.q_clr = 1'b1;
            if (!stat_i.slot_ok) begin
              state_d = S_OUT;
            end else if (stat_i.len_full) begin
              cmd_o.set_full = 1'b1;
              state_d        = S_OUT;
            end else if (stat_i.len_zero) begin
              state_d = S_FIN;
            end else begin
              cmd_o.rd_tail = 1'b1;
              state_d       = S_TAILW;
            end
          end
        endcase
      end
      S_SLOT: begin
        if (stat_i.len_zero) begin
          if (stat_i.last_slot) begin
            state_d = S_TOTAL;
          end else begin
            cmd_o.slot_next = 1'b1;
          end
        end else if (stat_i.pos_eq_len) begin
          cmd_o.rd_tail = 1'b1;
          state_d       = S_TAILW;
        end else begin
          cmd_o.q_from_pos = 1'b1;
          state_d          = S_STEP;
        end
      end
      S_TAILW: begin
        cmd_o.q_from_fail = 1'b1;
        state_d           = S_STEP;
      end
      S_STEP: begin
        // wait for the character and failure reads at the new position
        state_d = S_CMP;
      end
      S_CMP: begin
        // extend on a hit, else follow the failure link
        if (stat_i.sym_eq) begin
          cmd_o.q_inc = 1'b1;
          state_d     = S_FIN;
        end else if (!stat_i.q_zero) begin
          cmd_o.q_from_fail = 1'b1;
          state_d           = S_STEP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.cmd == CMD_APPEND) begin
          cmd_o.wr_append = 1'b1;
          state_d         = S_OUT;
        end else begin
          cmd_o.wr_text = 1'b1;
          if (stat_i.last_slot) begin
            state_d = S_TOTAL;
          end else begin
            cmd_o.slot_next = 1'b1;
            state_d         = S_SLOT;
          end
        end
      end
      S_TOTAL: begin
        cmd_o.add_total = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: begin
        // load the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/mpk_dp.sv =====
// ----------------------------------------------------------------------------
// mpk_dp
// Datapath: pattern and failure RAMs, slot state, counters, output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpk_dp import mpk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mpk_in_t   in_data_i,
  input  mpk_cmd_t  cmd_i,
  output mpk_stat_t stat_o,
  output mpk_out_t  out_data_o
);

  mpk_in_t             in_q;
  logic                full_q;
  logic [SlotW-1:0]    s_q;
  logic [PosW-1:0]     q_q;
  logic [HitW-1:0]     hits_q;
  logic [COUNT_WIDTH-1:0] total_q;
  logic [PosW-1:0]     plen_q [MAX_PATTERNS];
  logic [PosW-1:0]     mpos_q [MAX_PATTERNS];
  mpk_out_t            out_q;

  logic [SlotW-1:0]    cur;
  logic [PosW-1:0]     len;
  logic [PosW-1:0]     pos;
  logic [CellAw-1:0]   chr_raddr;
  logic [CellAw-1:0]   fail_raddr;
  logic [CellAw-1:0]   waddr;
  logic [7:0]          chr_rdata;
  logic [PosW-1:0]     fail_rdata;
  logic [COUNT_WIDTH:0] sum;

  // Slot under work: input slot for append, scan counter for text
  assign cur = (in_q.cmd == CMD_APPEND) ? SlotW'(in_q.slot) : s_q;
  assign len = plen_q[cur];
  assign pos = mpos_q[cur];

  // RAM addresses
  assign chr_raddr = cell_addr(cur, q_q);
  assign waddr     = cell_addr(cur, len);
  always_comb begin
    if (cmd_i.rd_tail) begin
      fail_raddr = cell_addr(cur, len - PosW'(1));
    end else if (q_q == '0) begin
      fail_raddr = cell_addr(cur, q_q);
    end else begin
      fail_raddr = cell_addr(cur, q_q - PosW'(1));
    end
  end

  mpk_ram #(.Width(8), .Depth(Cells), .AddrW(CellAw)) u_chars (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_append),
    .waddr_i (waddr),
    .wdata_i (in_q.symbol),
    .raddr_i (chr_raddr),
    .rdata_o (chr_rdata)
  );

  mpk_ram #(.Width(PosW), .Depth(Cells), .AddrW(CellAw)) u_fail (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_append),
    .waddr_i (waddr),
    .wdata_i (q_q),
    .raddr_i (fail_raddr),
    .rdata_o (fail_rdata)
  );

  // Status back to the controller
  assign stat_o.cmd        = in_q.cmd;
  assign stat_o.slot_ok    = 32'(in_q.slot) < MAX_PATTERNS;
  assign stat_o.len_zero   = (len == '0);
  assign stat_o.len_full   = (len == PosW'(MAX_PATTERN_LEN));
  assign stat_o.pos_eq_len = (pos == len);
  assign stat_o.q_zero     = (q_q == '0);
  assign stat_o.sym_eq     = (chr_rdata == in_q.symbol);
  assign stat_o.last_slot  = (s_q == SlotW'(MAX_PATTERNS - 1));

  assign sum = {1'b0, total_q} + (COUNT_WIDTH + 1)'(hits_q);

  // Input word, scan registers and count
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.slot_init) begin
      s_q <= '0;
    end else if (cmd_i.slot_next) begin
      s_q <= s_q + SlotW'(1);
    end
    if (cmd_i.q_clr) begin
      q_q <= '0;
    end else if (cmd_i.q_from_pos) begin
      q_q <= pos;
    end else if (cmd_i.q_from_fail) begin
      q_q <= fail_rdata;
    end else if (cmd_i.q_inc) begin
      q_q <= q_q + PosW'(1);
    end
    if (cmd_i.hits_clr) begin
      hits_q <= '0;
    end else if (cmd_i.wr_text && (q_q == len)) begin
      hits_q <= hits_q + HitW'(1);
    end
  end

  // Slot lengths, match positions, total and full flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PATTERNS; i++) begin
        plen_q[i] <= '0;
        mpos_q[i] <= '0;
      end
      total_q <= '0;
      full_q  <= 1'b0;
    end else begin
      if (cmd_i.latch_in) begin
        full_q <= 1'b0;
      end else if (cmd_i.set_full) begin
        full_q <= 1'b1;
      end
      if (cmd_i.clr_all) begin
        for (int i = 0; i < MAX_PATTERNS; i++) begin
          plen_q[i] <= '0;
          mpos_q[i] <= '0;
        end
        total_q <= '0;
      end else if (cmd_i.clr_pos) begin
        for (int i = 0; i < MAX_PATTERNS; i++) begin
          mpos_q[i] <= '0;
        end
      end else if (cmd_i.wr_text) begin
        mpos_q[cur] <= q_q;
      end else if (cmd_i.wr_append) begin
        mpos_q[cur] <= '0;
        plen_q[cur] <= len + PosW'(1);
      end
      if (cmd_i.add_total) begin
        if (sum[COUNT_WIDTH]) begin
          total_q <= '1;
        end else begin
          total_q <= sum[COUNT_WIDTH-1:0];
        end
      end
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.total_matches <= 16'(total_q);
      out_q.matched_now   <= (32'(hits_q) > 32'd31) ? 5'd31 : 5'(hits_q);
      out_q.text_done     <= (in_q.cmd == CMD_END);
      out_q.slot_full     <= full_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hdl/multi_pattern_kmp_counter.sv =====
// Clear, end of text and a dropped append go straight to the output register;
// an append to a filled slot first walks failure links from its tail. A text
// word visits every slot and walks failure links for each filled one. One word
// at a time: the next word is taken once the last result is in the output reg.
// Reset: asynchronous, clears lengths, positions, total and output valid.
// ----------------------------------------------------------------------------
// multi_pattern_kmp_counter
// Counts occurrences of up to 16 patterns in a text stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_pattern_kmp_counter import mpk_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mpk_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mpk_out_t out_data_o
);

  mpk_cmd_t  cmd;
  mpk_stat_t stat;

  // Sequencer
  mpk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Storage and arithmetic
  mpk_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

// ===== hdl/mpk_checker.sv =====
// ----------------------------------------------------------------------------
// mpk_checker
// Port-level checks of the match counter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mpk_checker import mpk_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input mpk_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input mpk_out_t out_data_o
);

  // Hold a stalled result word
  `ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // One word in flight: busy right after an accept
  `ASSERT_CLK(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o)

  // End-of-text words report no hits and no dropped character
  `ASSERT_IMPL(a_done_clean, out_valid_o && out_data_o.text_done,
               out_data_o.matched_now == 5'd0 && !out_data_o.slot_full)

  // A dropped-character word reports no hits
  `ASSERT_IMPL(a_full_clean, out_valid_o && out_data_o.slot_full,
               out_data_o.matched_now == 5'd0)

endmodule

bind multi_pattern_kmp_counter mpk_checker u_mpk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Multi-pattern KMP counter testbench
// Drives pattern, text, clear and end-of-text words and checks every result
// against a behavioral occurrence counter kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mpk_pkg::*;

  localparam int CycleLimit = 10000000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  mpk_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  mpk_out_t out_data_o;

  multi_pattern_kmp_counter dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #2 clk_i = ~clk_i;

  // Bench copy of the counter state
  logic [7:0]  pat_sym  [MAX_PATTERNS][MAX_PATTERN_LEN];
  int unsigned pat_len  [MAX_PATTERNS];
  int unsigned pat_fail [MAX_PATTERNS][MAX_PATTERN_LEN];
  int unsigned pat_pos  [MAX_PATTERNS];
  int unsigned occ_total;
  mpk_out_t    pending_results[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;
  longint cycles = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // Walk failure links until symbol c extends position q
  function automatic int unsigned kmp_step(int s, int unsigned q, logic [7:0] c);
    while (q > 0 && pat_sym[s][q] != c) q = pat_fail[s][q-1];
    if (pat_sym[s][q] == c) q++;
    return q;
  endfunction

  function automatic mpk_out_t count_word(mpk_in_t w);
    mpk_out_t r;
    int unsigned hits, q, k, len;
    r = '0;
    hits = 0;
    case (w.cmd)
      CMD_CLEAR: begin
        foreach (pat_len[s]) begin pat_len[s] = 0; pat_pos[s] = 0; end
        occ_total = 0;
      end
      CMD_APPEND: begin
        len = pat_len[w.slot];
        if (len >= MAX_PATTERN_LEN) begin
          r.slot_full = 1'b1;
        end else begin
          k = 0;
          if (len > 0) k = kmp_step(w.slot, pat_fail[w.slot][len-1], w.symbol);
          pat_sym[w.slot][len] = w.symbol;
          pat_fail[w.slot][len] = k;
          pat_len[w.slot] = len + 1;
          pat_pos[w.slot] = 0;
        end
      end
      CMD_TEXT: begin
        for (int s = 0; s < MAX_PATTERNS; s++) begin
          if (pat_len[s] != 0) begin
            q = pat_pos[s];
            if (q >= pat_len[s]) q = pat_fail[s][pat_len[s]-1];
            q = kmp_step(s, q, w.symbol);
            if (q == pat_len[s]) hits++;
            pat_pos[s] = q;
          end
        end
        occ_total += hits;
        if (occ_total > 65535) occ_total = 65535;
        r.matched_now = (hits > 31) ? 5'd31 : hits[4:0];
      end
      default: begin
        foreach (pat_pos[s]) pat_pos[s] = 0;
        r.text_done = 1'b1;
      end
    endcase
    r.total_matches = occ_total[15:0];
    return r;
  endfunction

  // Send one word, hold it until accepted
  task automatic send_word(input cmd_e c, input logic [3:0] s, input logic [7:0] y);
    mpk_in_t w;
    w.cmd = c; w.slot = s; w.symbol = y;
    // Idle with valid low, then offer the word
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_data_i <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(count_word(w));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  // Receiver ready pattern
  always @(negedge clk_i) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    mpk_out_t want;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.total_matches !== want.total_matches)
          report("total_matches", out_data_o.total_matches, want.total_matches);
        if (out_data_o.matched_now !== want.matched_now)
          report("matched_now", out_data_o.matched_now, want.matched_now);
        if (out_data_o.text_done !== want.text_done)
          report("text_done", out_data_o.text_done, want.text_done);
        if (out_data_o.slot_full !== want.slot_full)
          report("slot_full", out_data_o.slot_full, want.slot_full);
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(CMD_TEXT, 4'd0, 8'h41);
    send_word(CMD_APPEND, 4'd0, 8'h61);
    send_word(CMD_APPEND, 4'd0, 8'h61);
    send_word(CMD_APPEND, 4'd15, 8'hFF);
    send_word(CMD_APPEND, 4'd15, 8'h00);
    repeat (5) send_word(CMD_TEXT, 4'hF, 8'h61);
    send_word(CMD_TEXT, 4'd0, 8'hFF);
    send_word(CMD_TEXT, 4'd0, 8'h00);
    send_word(CMD_APPEND, 4'd0, 8'h62);
    send_word(CMD_TEXT, 4'd0, 8'h61);
    send_word(CMD_END, 4'hA, 8'h55);
    send_word(CMD_TEXT, 4'd0, 8'h61);
    send_word(CMD_CLEAR, 4'h5, 8'hAA);
    // Fill one slot past its capacity
    repeat (MAX_PATTERN_LEN + 2) send_word(CMD_APPEND, 4'd7, 8'h61);
    send_word(CMD_TEXT, 4'd0, 8'h61);
    drain();
  endtask

  // Patterns and texts mostly over a small alphabet, with an occasional random symbol
  task automatic test_random(input int n_words);
    int sent;
    sent = 0;
    while (sent < n_words) begin
      send_word(CMD_CLEAR, 4'($urandom), 8'($urandom));
      sent++;
      repeat ($urandom_range(1, 40)) begin
        send_word(CMD_APPEND, 4'($urandom),
                  ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(97, 99)));
        sent++;
      end
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(5, 40)) begin
          case ($urandom_range(19))
            0: send_word(CMD_APPEND, 4'($urandom), 8'($urandom_range(97, 99)));
            1: send_word(CMD_TEXT, 4'($urandom), 8'($urandom));
            default: send_word(CMD_TEXT, 4'($urandom), 8'($urandom_range(97, 99)));
          endcase
          sent++;
        end
        send_word(CMD_END, 4'($urandom), 8'($urandom));
        sent++;
      end
    end
    drain();
  endtask

  // Hold off the receiver so the block backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_hold = 400;
    repeat (20) send_word(CMD_TEXT, 4'd0, 8'($urandom_range(97, 99)));
    drain();
  endtask

  // Every slot holds the same one-character pattern and hits on each word
  task automatic test_all_slots_hit();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_word(CMD_CLEAR, 4'd0, 8'd0);
    for (int s = 0; s < MAX_PATTERNS; s++) send_word(CMD_APPEND, 4'(s), 8'h7A);
    repeat (150) send_word(CMD_TEXT, 4'd0, 8'h7A);
    drain();
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    send_idle_pct = 36; recv_idle_pct = 60;
    test_random(400);
    send_idle_pct = 60; recv_idle_pct = 36;
    test_random(400);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(400);
    test_backpressure();
    test_all_slots_hit();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
